### rtl/core/tsip_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the TSIP timing packet parser.
// No dependencies; imported by every module of the block.
package tsip_pkg;

	localparam int unsigned BUF_BYTES = 128;

	localparam logic [7:0] SYM_DLE  = 8'h10;
	localparam logic [7:0] SYM_ETX  = 8'h03;
	localparam logic [7:0] PKT_ID   = 8'h8f;
	localparam logic [7:0] SUB_TIME = 8'hab;
	localparam logic [7:0] SUB_QERR = 8'hac;
	localparam logic [7:0] FLAG_MASK = 8'h04 | 8'h08;
	// minimum byte count of a time packet, and count a quant packet must exceed
	localparam logic [7:0] TIME_MIN_BYTES = 8'd19;
	localparam logic [7:0] QERR_MIN_BYTES = 8'd65;
	localparam logic [15:0] TIMEOUT_RESET = 16'd50;

	typedef enum logic [1:0] {
		ST_UNKNOWN  = 2'd0,
		ST_CONTINUE = 2'd1,
		ST_COMPLETE = 2'd2
	} status_t;

	// buffer positions that are ever inspected, captured as they stream by
	localparam int unsigned NCAP = 14;
	localparam int unsigned CAP_ID  = 0;
	localparam int unsigned CAP_SUB = 1;
	localparam int unsigned CAP_FLG = 2;
	localparam int unsigned CAP_SEC = 3;
	localparam int unsigned CAP_MIN = 4;
	localparam int unsigned CAP_HR  = 5;
	localparam int unsigned CAP_DAY = 6;
	localparam int unsigned CAP_MON = 7;
	localparam int unsigned CAP_YRH = 8;
	localparam int unsigned CAP_YRL = 9;
	localparam int unsigned CAP_Q3  = 10;
	localparam int unsigned CAP_Q2  = 11;
	localparam int unsigned CAP_Q1  = 12;
	localparam int unsigned CAP_Q0  = 13;

	localparam logic [7:0] CAP_IDX [NCAP] = '{
		8'd1, 8'd2, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18,
		8'd62, 8'd63, 8'd64, 8'd65
	};

	// one classified request handed from the framer to the output side
	typedef struct packed {
		status_t     status;
		logic        time_ok;
		logic        quant_ok;
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [31:0] quant;
	} res_t;

endpackage

### rtl/core/tsip_front.sv
`timescale 1ns / 1ps
// Framer: accepts bytes and ticks, tracks DLE parity, idle time and byte count,
// and classifies each byte into a result request. Depends on tsip_pkg.
module tsip_front import tsip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        cmd,
	input  logic [7:0]  byte_value,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	output logic        push,
	output res_t        push_data
);

	logic [15:0] timeout_q;
	logic [15:0] idle_q;
	logic [7:0]  bcnt_q;
	logic [7:0]  dcnt_q;
	logic [7:0]  cap_q [NCAP];

	logic [7:0]  cap_nxt [NCAP];
	logic        timed_out;
	logic [7:0]  bc_eff;
	logic [7:0]  dc_eff;
	logic [7:0]  dc_inc;
	logic [7:0]  bc_inc;
	logic        is_dle;
	logic        wr_buf;
	logic [7:0]  bc_d;
	logic [7:0]  dc_d;
	logic        time_pkt;
	logic        quant_pkt;
	res_t        res;

	assign is_dle    = (byte_value == SYM_DLE);
	assign timed_out = (idle_q > timeout_q);
	assign bc_eff    = timed_out ? 8'd0 : bcnt_q;
	assign dc_eff    = timed_out ? 8'd0 : dcnt_q;
	assign dc_inc    = is_dle ? dc_eff + 8'd1 : dc_eff;
	assign bc_inc    = bc_eff + 8'd1;

	always_comb begin
		for (int k = 0; k < NCAP; k++) begin
			cap_nxt[k] = (wr_buf && bc_eff == CAP_IDX[k]) ? byte_value : cap_q[k];
		end
	end

	assign time_pkt = (bc_inc >= TIME_MIN_BYTES) && (cap_nxt[CAP_ID] == PKT_ID)
		&& (cap_nxt[CAP_SUB] == SUB_TIME);
	assign quant_pkt = (bc_inc > QERR_MIN_BYTES) && (cap_nxt[CAP_ID] == PKT_ID)
		&& (cap_nxt[CAP_SUB] == SUB_QERR);

	always_comb begin
		wr_buf = 1'b0;
		bc_d   = bc_eff;
		dc_d   = dc_inc;
		res    = '0;
		res.status = ST_CONTINUE;
		res.year   = {cap_nxt[CAP_YRH], cap_nxt[CAP_YRL]};
		res.month  = cap_nxt[CAP_MON];
		res.day    = cap_nxt[CAP_DAY];
		res.hour   = cap_nxt[CAP_HR];
		res.minute = cap_nxt[CAP_MIN];
		res.second = cap_nxt[CAP_SEC];
		res.quant  = {cap_nxt[CAP_Q3], cap_nxt[CAP_Q2], cap_nxt[CAP_Q1], cap_nxt[CAP_Q0]};
		priority if (is_dle && dc_inc > 8'd2 && dc_inc[0]) begin
			// stuffed DLE: drop it
			res.status = ST_CONTINUE;
		end else if (!is_dle && dc_eff == 8'd0) begin
			res.status = ST_UNKNOWN;
		end else if (bc_eff >= 8'(BUF_BYTES)) begin
			bc_d = 8'd0;
			dc_d = 8'd0;
			res.status = ST_UNKNOWN;
		end else if (byte_value == SYM_ETX && !dc_inc[0]) begin
			wr_buf = 1'b1;
			bc_d   = 8'd0;
			dc_d   = 8'd0;
			res.status   = ST_COMPLETE;
			res.time_ok  = time_pkt && ((cap_nxt[CAP_FLG] & FLAG_MASK) == 8'd0);
			res.quant_ok = !time_pkt && quant_pkt;
		end else begin
			wr_buf = 1'b1;
			bc_d   = bc_inc;
			res.status = ST_CONTINUE;
		end
	end

	assign push      = accept && !cmd;
	assign push_data = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			idle_q    <= '0;
			bcnt_q    <= '0;
			dcnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
			if (accept && cmd) begin
				if (idle_q != 16'hffff) begin
					idle_q <= idle_q + 16'd1;
				end
			end else if (accept) begin
				idle_q <= '0;
				bcnt_q <= bc_d;
				dcnt_q <= dc_d;
			end
		end
	end

	// capture only the buffer positions that are later inspected
	always_ff @(posedge clk) begin
		if (push) begin
			for (int k = 0; k < NCAP; k++) begin
				cap_q[k] <= cap_nxt[k];
			end
		end
	end

endmodule

### rtl/core/tsip_queue.sv
`timescale 1ns / 1ps
// Two-entry request queue between the framer and the output stage.
// Depends on tsip_pkg for the request type.
module tsip_queue import tsip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output res_t pop_data
);

	res_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/tsip_back.sv
`timescale 1ns / 1ps
// Output stage: pops requests, clears fields of absent reports and holds
// the result register toward the receiver. Depends on tsip_pkg.
module tsip_back import tsip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  res_t        q_data,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        time_valid,
	output logic [15:0] year,
	output logic [7:0]  month,
	output logic [7:0]  day,
	output logic [7:0]  hour,
	output logic [7:0]  minute,
	output logic [7:0]  second,
	output logic        quant_valid,
	output logic [31:0] quant_bits
);

	logic out_valid_q;
	res_t out_q;
	res_t pop_clean;

	assign q_pop = q_not_empty && (!out_valid_q || out_ready);

	// zero the payload of reports that did not occur
	always_comb begin
		pop_clean = q_data;
		if (!q_data.time_ok) begin
			pop_clean.year   = '0;
			pop_clean.month  = '0;
			pop_clean.day    = '0;
			pop_clean.hour   = '0;
			pop_clean.minute = '0;
			pop_clean.second = '0;
		end
		if (!q_data.quant_ok) begin
			pop_clean.quant = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= pop_clean;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign time_valid  = out_q.time_ok;
	assign year        = out_q.year;
	assign month       = out_q.month;
	assign day         = out_q.day;
	assign hour        = out_q.hour;
	assign minute      = out_q.minute;
	assign second      = out_q.second;
	assign quant_valid = out_q.quant_ok;
	assign quant_bits  = out_q.quant;

endmodule

### rtl/core/tsip_timing_packet_parser_top.sv
`timescale 1ns / 1ps
// TSIP timing packet parser, top level: framer, request queue, output stage.
// Depends on tsip_pkg, tsip_front, tsip_queue and tsip_back.
//
// Input channel (in_valid/in_ready): cmd 0 carries a received byte in
// byte_value, cmd 1 is one idle tick. Every byte yields exactly one result
// on the output channel (out_valid/out_ready); ticks yield none.
// Status reports out of sync, continue or packet complete; on completion of
// an 8F-AB packet with full time flags the UTC fields are reported, on an
// 8F-AC packet the raw quantization error bits.
// Config channel (cfg_valid/cfg_ready) writes timeout_ticks; always ready.
// Write it only while the block is idle.
// A byte's result is written into a queue entry, then into the output register.
// Throughput: one item per cycle while the queue is not full.
// When the receiver stalls, the output register holds and the two-entry
// queue fills; in_ready drops only when the queue is full.
// Reset: counters and idle time cleared, timeout_ticks back to 50, no
// result pending.
module tsip_timing_packet_parser_top import tsip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  byte_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        time_valid,
	output logic [15:0] year,
	output logic [7:0]  month,
	output logic [7:0]  day,
	output logic [7:0]  hour,
	output logic [7:0]  minute,
	output logic [7:0]  second,
	output logic        quant_valid,
	output logic [31:0] quant_bits
);

	logic q_full;
	logic q_not_empty;
	logic q_pop;
	logic push;
	res_t push_data;
	res_t q_data;

	assign in_ready  = !q_full;
	assign cfg_ready = 1'b1;

	tsip_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_valid && !q_full),
		.cmd        (cmd),
		.byte_value (byte_value),
		.cfg_we     (cfg_valid),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_data  (push_data)
	);

	tsip_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_data)
	);

	tsip_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.time_valid  (time_valid),
		.year        (year),
		.month       (month),
		.day         (day),
		.hour        (hour),
		.minute      (minute),
		.second      (second),
		.quant_valid (quant_valid),
		.quant_bits  (quant_bits)
	);

endmodule

### bench/tsip_timing_packet_parser_top_test.sv
`timescale 1ns / 1ps
// Testbench for tsip_timing_packet_parser_top: feeds DLE/ETX framed TSIP streams and idle
// ticks, predicts every per-byte report and checks it on the output channel.
// Depends on tsip_pkg and the parser RTL; needs no files or arguments.
module tsip_timing_packet_parser_top_test;
	import tsip_pkg::*;

	typedef struct packed {
		status_t     status;
		logic        time_valid;
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic        quant_valid;
		logic [31:0] quant_bits;
	} parse_report_t;

	typedef struct packed {
		logic       is_tick;
		logic [7:0] data;
	} rx_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd = 1'b0;
	logic [7:0]  byte_value = 8'h00;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic        time_valid;
	logic [15:0] year;
	logic [7:0]  month;
	logic [7:0]  day;
	logic [7:0]  hour;
	logic [7:0]  minute;
	logic [7:0]  second;
	logic        quant_valid;
	logic [31:0] quant_bits;

	// framer model state
	logic [7:0]  frame_buf [BUF_BYTES];
	logic [7:0]  frame_len = '0;
	logic [7:0]  dle_seen = '0;
	logic [15:0] idle_seen = '0;
	logic [15:0] timeout_ticks = TIMEOUT_RESET;

	rx_item_t      rx_items [$];
	parse_report_t expected_reports [$];
	logic [7:0]    frame_body [$];
	int            items_total = 0;
	int            items_taken = 0;
	int            frames_sent = 0;
	int            err_count = 0;
	bit            no_gaps = 1'b0;

	tsip_timing_packet_parser_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.byte_value (byte_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.time_valid (time_valid),
		.year       (year),
		.month      (month),
		.day        (day),
		.hour       (hour),
		.minute     (minute),
		.second     (second),
		.quant_valid(quant_valid),
		.quant_bits (quant_bits)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void parse_rx_item(input rx_item_t it);
		parse_report_t rep;
		rep = '0;
		if (it.is_tick) begin
			if (idle_seen != 16'hffff)
				idle_seen = idle_seen + 16'd1;
			return;
		end
		if (idle_seen > timeout_ticks) begin
			frame_len = '0;
			dle_seen = '0;
		end
		idle_seen = '0;
		if (it.data == SYM_DLE)
			dle_seen = dle_seen + 8'd1;
		if (it.data == SYM_DLE && dle_seen > 8'd2 && dle_seen[0]) begin
			// drop the stuffing DLE
			rep.status = ST_CONTINUE;
		end else if (it.data != SYM_DLE && dle_seen == 8'd0) begin
			rep.status = ST_UNKNOWN;
		end else if (frame_len >= BUF_BYTES) begin
			frame_len = '0;
			dle_seen = '0;
			rep.status = ST_UNKNOWN;
		end else begin
			frame_buf[frame_len] = it.data;
			frame_len = frame_len + 8'd1;
			if (it.data == SYM_ETX && !dle_seen[0]) begin
				rep.status = ST_COMPLETE;
				if (frame_len >= TIME_MIN_BYTES && frame_buf[1] == PKT_ID &&
						frame_buf[2] == SUB_TIME) begin
					if ((frame_buf[11] & FLAG_MASK) == 8'h00) begin
						rep.time_valid = 1'b1;
						rep.year = {frame_buf[17], frame_buf[18]};
						rep.month = frame_buf[16];
						rep.day = frame_buf[15];
						rep.hour = frame_buf[14];
						rep.minute = frame_buf[13];
						rep.second = frame_buf[12];
					end
				end else if (frame_len > QERR_MIN_BYTES && frame_buf[1] == PKT_ID &&
						frame_buf[2] == SUB_QERR) begin
					rep.quant_valid = 1'b1;
					rep.quant_bits = {frame_buf[62], frame_buf[63], frame_buf[64], frame_buf[65]};
				end
				frame_len = '0;
				dle_seen = '0;
			end else begin
				rep.status = ST_CONTINUE;
			end
		end
		expected_reports.push_back(rep);
	endfunction

	function automatic string report_text(input parse_report_t r);
		return $sformatf("st %0d tv %0d %0d-%0d-%0d %0d:%0d:%0d qv %0d q %h", r.status,
			r.time_valid, r.year, r.month, r.day, r.hour, r.minute, r.second,
			r.quant_valid, r.quant_bits);
	endfunction

	function automatic void note_error(input string what);
		err_count++;
		if (err_count <= 10)
			$display("%0t: %s", $time, what);
	endfunction

	// favor DLE and ETX so stuffing and false ends show up often
	function automatic logic [7:0] rand_data();
		case ($urandom_range(9))
			0: return SYM_DLE;
			1: return SYM_ETX;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				parse_rx_item('{is_tick: cmd, data: byte_value});
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (rx_items.size() != 0 && (no_gaps || $urandom_range(99) >= 30)) begin
					in_valid <= 1'b1;
					cmd <= rx_items[0].is_tick;
					byte_value <= rx_items[0].data;
					void'(rx_items.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// report monitor
	always @(posedge clk) begin : check_reports
		parse_report_t seen;
		parse_report_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				seen = '{status: status_t'(status), time_valid: time_valid, year: year,
					month: month, day: day, hour: hour, minute: minute, second: second,
					quant_valid: quant_valid, quant_bits: quant_bits};
				if (expected_reports.size() == 0) begin
					note_error({"unexpected report: ", report_text(seen)});
				end else begin
					want = expected_reports.pop_front();
					if (seen.status !== want.status || seen.time_valid !== want.time_valid ||
							seen.year !== want.year || seen.month !== want.month ||
							seen.day !== want.day || seen.hour !== want.hour ||
							seen.minute !== want.minute || seen.second !== want.second ||
							seen.quant_valid !== want.quant_valid ||
							seen.quant_bits !== want.quant_bits)
						note_error({"expected ", report_text(want), " got ", report_text(seen)});
				end
			end
			out_ready <= no_gaps || ($urandom_range(99) >= 30);
		end
	end

	task automatic queue_byte(input logic [7:0] v);
		rx_items.push_back('{is_tick: 1'b0, data: v});
		items_total++;
	endtask

	task automatic queue_ticks(input int n);
		repeat (n) begin
			rx_items.push_back('{is_tick: 1'b1, data: 8'($urandom_range(255))});
			items_total++;
		end
	endtask

	task automatic build_body(input logic [7:0] id, input logic [7:0] sub, input int len);
		frame_body.delete();
		for (int i = 0; i < len; i++)
			frame_body.push_back(i == 0 ? id : (i == 1 ? sub : rand_data()));
	endtask

	task automatic build_time(input logic [7:0] flags, input int len);
		build_body(PKT_ID, SUB_TIME, len);
		if (len > 10)
			frame_body[10] = flags;
	endtask

	// send DLE, the stuffed body up to keep bytes, an idle gap before byte gap_at,
	// and the DLE ETX trailer only when the whole body went out
	task automatic queue_frame(input int keep, input int gap_at, input int gap_len);
		queue_byte(SYM_DLE);
		foreach (frame_body[i]) begin
			if (i < keep) begin
				if (i == gap_at)
					queue_ticks(gap_len);
				queue_byte(frame_body[i]);
				if (frame_body[i] == SYM_DLE)
					queue_byte(SYM_DLE);
			end
		end
		if (keep >= frame_body.size()) begin
			queue_byte(SYM_DLE);
			queue_byte(SYM_ETX);
			frames_sent++;
		end
	endtask

	task automatic queue_whole();
		queue_frame(frame_body.size(), -1, 0);
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (items_taken != items_total || expected_reports.size() != 0);
		// ticks leave no report, so give the last ones time to land
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		timeout_ticks = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int budget);
		int first_item;
		int first_frame;
		int len;
		int gap;
		first_item = items_total;
		first_frame = frames_sent;
		while (items_total - first_item < budget || frames_sent - first_frame < 2) begin
			// gaps reach the timeout only when it is short
			if (timeout_ticks <= 16'd64)
				gap = int'(timeout_ticks) + $urandom_range(0, 2);
			else
				gap = $urandom_range(0, 5);
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					case ($urandom_range(9))
						0: len = $urandom_range(2, 15);
						1: len = $urandom_range(16, 24);
						default: len = 17;
					endcase
					build_time($urandom_range(1) ? (rand_data() & ~FLAG_MASK) : rand_data(), len);
					if ($urandom_range(3) == 0)
						queue_frame(len, $urandom_range(0, len - 1), gap);
					else
						queue_whole();
				end
				4, 5: begin
					case ($urandom_range(9))
						0: len = $urandom_range(2, 62);
						1: len = $urandom_range(100, 130);
						default: len = $urandom_range(63, 72);
					endcase
					build_body(PKT_ID, SUB_QERR, len);
					queue_whole();
				end
				6: begin
					build_body(rand_data(), rand_data(), $urandom_range(0, 30));
					queue_whole();
				end
				7: begin
					build_time(rand_data(), 17);
					queue_frame($urandom_range(0, 16), -1, 0);
					queue_ticks(gap);
				end
				8: repeat ($urandom_range(1, 8)) queue_byte(rand_data());
				default: queue_ticks(gap);
			endcase
			queue_ticks($urandom_range(0, 2));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// bytes out of sync, ticks with nothing framed
		queue_byte(8'h00);
		queue_byte(8'hff);
		queue_byte(SYM_ETX);
		queue_ticks(3);
		// shortest time packet with data, its second to month fields all stuffed DLEs
		build_time(8'hff & ~FLAG_MASK, 16);
		for (int i = 11; i < 16; i++)
			frame_body[i] = SYM_DLE;
		queue_whole();
		// one byte short of it
		build_time(8'h00, 15);
		queue_whole();
		// incomplete time flags
		build_time(8'h04, 17);
		queue_whole();
		build_time(8'h08, 17);
		queue_whole();
		// shortest quant error packet with data
		build_body(PKT_ID, SUB_QERR, 63);
		frame_body[61] = 8'hff;
		frame_body[62] = 8'hff;
		queue_whole();
		// buffer overrun by the trailer
		build_body(PKT_ID, SUB_QERR, 126);
		queue_whole();

		// idle gap at the timeout, then one tick past it
		write_timeout(16'd2);
		build_time(8'h00, 17);
		queue_frame(17, 5, 2);
		build_time(8'h00, 17);
		queue_frame(17, 5, 3);
		random_phase(30);

		write_timeout(16'hffff);
		no_gaps = 1'b1;
		random_phase(30);
		drain();
		no_gaps = 1'b0;

		write_timeout(16'($urandom_range(3, 8)));
		random_phase(30);

		drain();
		if (err_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
